// ===== sv/dgru_pkg.sv =====
package dgru_pkg;

  // Field and register widths.
  localparam int VEL_W       = 16;
  localparam int CFG_W       = 14;
  localparam int MAXF_W      = 4;
  localparam int FOLD_STAGES = 16;

  // Stage index width: it must hold every stage number and every max_folds code.
  localparam int STAGE_W = $clog2(FOLD_STAGES + 1);
  localparam int IDX_W   = (STAGE_W > MAXF_W) ? STAGE_W : MAXF_W;

  // A folded value can drift from the gate value by at most FOLD_STAGES steps of
  // twice the Nyquist velocity. That sets the width of the working value.
  localparam int BASE_W = (VEL_W > CFG_W + 2) ? VEL_W : (CFG_W + 2);
  localparam int FOLD_W = BASE_W + $clog2(FOLD_STAGES + 1) + 1;
  localparam int DIFF_W = FOLD_W + 1;
  localparam int MAG_W  = (VEL_W + 1 > CFG_W + 1) ? (VEL_W + 1) : (CFG_W + 1);

  // Signed velocity range on the working width, used by the output clamp.
  localparam logic signed [FOLD_W-1:0] VEL_MAX_F =
    $signed({{(FOLD_W - VEL_W + 1){1'b0}}, {(VEL_W - 1){1'b1}}});
  localparam logic signed [FOLD_W-1:0] VEL_MIN_F =
    $signed({{(FOLD_W - VEL_W + 1){1'b1}}, {(VEL_W - 1){1'b0}}});

  // APB register map.
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NYQUIST    = 3'd0,
    REG_FOLD_LIMIT = 3'd1,
    REG_COMP_THR   = 3'd2,
    REG_MIN_SPEED  = 3'd3,
    REG_MAX_FOLDS  = 3'd4,
    REG_HAVE_LAST  = 3'd5
  } dgru_reg_e;

  // Settings that every fold stage needs.
  typedef struct packed {
    logic [CFG_W-1:0]  nyquist;
    logic [CFG_W-1:0]  fold_limit;
    logic [MAXF_W-1:0] max_folds;
  } dgru_fold_cfg_t;

  // Item as it travels through the fold pipeline.
  typedef struct packed {
    logic                     active;
    logic signed [FOLD_W-1:0] val;
    logic signed [VEL_W-1:0]  refv;
    logic signed [VEL_W-1:0]  gate;
    logic signed [VEL_W-1:0]  chk;
    logic                     chk_en;
  } dgru_fold_t;

endpackage

// ===== sv/dgru_gate_if.sv =====
interface dgru_gate_if;
  import dgru_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] gate_value;
  logic                    gate_present;
  logic                    gate_eligible;
  logic signed [VEL_W-1:0] prev_value;
  logic                    prev_present;
  logic signed [VEL_W-1:0] sound_value;
  logic                    sound_present;
  logic signed [VEL_W-1:0] above_value;
  logic                    above_present;

  modport source (
    output valid, gate_value, gate_present, gate_eligible, prev_value, prev_present,
           sound_value, sound_present, above_value, above_present,
    input  ready
  );

  modport sink (
    input  valid, gate_value, gate_present, gate_eligible, prev_value, prev_present,
           sound_value, sound_present, above_value, above_present,
    output ready
  );
endinterface

// ===== sv/dgru_result_if.sv =====
interface dgru_result_if;
  import dgru_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] result_value;
  logic                    accepted;
  logic                    saturated;

  modport source (
    output valid, result_value, accepted, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_value, accepted, saturated,
    output ready
  );
endinterface

// ===== sv/doppler_gate_reference_unfold.sv =====
// Channel   Dir  Payload                                         Handshake
// gate_i    in   gate, previous, sounding and above velocities   valid / ready
// result_o  out  result_value, accepted, saturated               valid / ready
// APB       in   six settings registers at byte address 4*index  psel / penable
//
// Acceptance to result runs through one entry register that picks the reference, one
// register stage per possible fold (16), one compare stage and one output register.
// Outside a stall, a new gate can enter in every cycle. When the result is not taken,
// the whole pipeline holds and gate_i.ready drops. Reset is asynchronous and active
// low; it clears the valid bits and loads the register defaults. The user must write
// settings only while the pipeline is empty; the block does not enforce this.
module doppler_gate_reference_unfold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dgru_gate_if.sink                         gate_i,
  dgru_result_if.source                     result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dgru_pkg::PADDR_W-1:0]      paddr,
  input  logic [dgru_pkg::PDATA_W-1:0]      pwdata,
  output logic [dgru_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import dgru_pkg::*;

  // ---------------------------------------------------------------------------
  // Settings registers. A write lands in the access phase of an APB transfer;
  // the bits above a register's width are dropped, unknown addresses ignored.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  nyquist_q;
  logic [CFG_W-1:0]  fold_limit_q;
  logic [CFG_W-1:0]  comp_thr_q;
  logic [CFG_W-1:0]  min_speed_q;
  logic [MAXF_W-1:0] max_folds_q;
  logic              have_last_q;
  logic              cfg_wr;
  dgru_reg_e         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dgru_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nyquist_q    <= CFG_W'(2000);
      fold_limit_q <= CFG_W'(2000);
      comp_thr_q   <= CFG_W'(500);
      min_speed_q  <= '0;
      max_folds_q  <= MAXF_W'(5);
      have_last_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NYQUIST:    nyquist_q    <= pwdata[CFG_W-1:0];
        REG_FOLD_LIMIT: fold_limit_q <= pwdata[CFG_W-1:0];
        REG_COMP_THR:   comp_thr_q   <= pwdata[CFG_W-1:0];
        REG_MIN_SPEED:  min_speed_q  <= pwdata[CFG_W-1:0];
        REG_MAX_FOLDS:  max_folds_q  <= pwdata[MAXF_W-1:0];
        REG_HAVE_LAST:  have_last_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NYQUIST:    prdata = PDATA_W'(nyquist_q);
      REG_FOLD_LIMIT: prdata = PDATA_W'(fold_limit_q);
      REG_COMP_THR:   prdata = PDATA_W'(comp_thr_q);
      REG_MIN_SPEED:  prdata = PDATA_W'(min_speed_q);
      REG_MAX_FOLDS:  prdata = PDATA_W'(max_folds_q);
      REG_HAVE_LAST:  prdata = PDATA_W'(have_last_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together; the pipeline stalls only when
  // the output register holds an item that the sink has not taken.
  // ---------------------------------------------------------------------------
  logic out_vld_q;
  logic pipe_en;

  assign pipe_en      = !out_vld_q || result_o.ready;
  assign gate_i.ready = pipe_en;

  // ---------------------------------------------------------------------------
  // Entry stage: decide whether the gate is worked on, and pick the reference
  // it folds toward and the second reference it must also agree with.
  // ---------------------------------------------------------------------------
  logic signed [MAG_W-1:0] gate_x;
  logic signed [MAG_W-1:0] gate_mag;
  logic                    fast;
  dgru_fold_t              ent_d;
  dgru_fold_t              ent_q;
  logic                    ent_vld_q;

  assign gate_x   = MAG_W'(gate_i.gate_value);
  assign gate_mag = gate_x[MAG_W-1] ? -gate_x : gate_x;
  assign fast     = gate_mag > $signed(MAG_W'(min_speed_q));

  always_comb begin
    ent_d        = '0;
    ent_d.val    = FOLD_W'(gate_i.gate_value);
    ent_d.gate   = gate_i.gate_value;
    ent_d.refv   = gate_i.sound_value;
    ent_d.chk    = gate_i.sound_value;
    ent_d.chk_en = 1'b0;
    if (!have_last_q) begin
      // Sounding mode. With the sweep above present, fold toward it and check
      // the result against the sounding as well.
      ent_d.active = gate_i.sound_present;
      if (gate_i.above_present) begin
        ent_d.refv   = gate_i.above_value;
        ent_d.chk_en = 1'b1;
      end
    end else begin
      // Previous-volume mode needs both the previous volume and the sweep above.
      ent_d.active = gate_i.prev_present && gate_i.above_present;
      ent_d.refv   = gate_i.prev_value;
      ent_d.chk    = gate_i.above_value;
      ent_d.chk_en = 1'b1;
    end
    ent_d.active = ent_d.active && gate_i.gate_eligible && gate_i.gate_present && fast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (pipe_en) begin
      ent_vld_q <= gate_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ent_q <= ent_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Fold stages. Stage n applies fold number n when it is within max_folds and
  // the value is still farther than fold_limit from the reference. Once close
  // enough, later stages see the same distance and leave the value alone.
  // ---------------------------------------------------------------------------
  dgru_fold_cfg_t fold_cfg;
  logic           fold_vld [FOLD_STAGES+1];
  dgru_fold_t     fold_item [FOLD_STAGES+1];

  assign fold_cfg.nyquist    = nyquist_q;
  assign fold_cfg.fold_limit = fold_limit_q;
  assign fold_cfg.max_folds  = max_folds_q;
  assign fold_vld[0]         = ent_vld_q;
  assign fold_item[0]        = ent_q;

  for (genvar s = 0; s < FOLD_STAGES; s++) begin : g_fold
    dgru_fold_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .idx_i  (IDX_W'(s)),
      .cfg_i  (fold_cfg),
      .vld_i  (fold_vld[s]),
      .item_i (fold_item[s]),
      .vld_o  (fold_vld[s+1]),
      .item_o (fold_item[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Compare stage: the folded value must lie strictly within comp_threshold of
  // the reference, and of the second reference where there is one.
  // ---------------------------------------------------------------------------
  dgru_fold_t               last;
  logic signed [DIFF_W-1:0] thr;
  logic signed [DIFF_W-1:0] d_ref;
  logic signed [DIFF_W-1:0] d_chk;
  logic                     near_ref;
  logic                     near_chk;
  logic                     acc_d;
  logic                     cmp_vld_q;
  logic                     cmp_acc_q;
  logic signed [FOLD_W-1:0] cmp_val_q;
  logic signed [VEL_W-1:0]  cmp_gate_q;

  assign last     = fold_item[FOLD_STAGES];
  assign thr      = $signed(DIFF_W'(comp_thr_q));
  assign d_ref    = DIFF_W'(last.refv) - DIFF_W'(last.val);
  assign d_chk    = DIFF_W'(last.chk) - DIFF_W'(last.val);
  assign near_ref = d_ref[DIFF_W-1] ? (d_ref > -thr) : (d_ref < thr);
  assign near_chk = d_chk[DIFF_W-1] ? (d_chk > -thr) : (d_chk < thr);
  assign acc_d    = last.active && near_ref && (!last.chk_en || near_chk);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else if (pipe_en) begin
      cmp_vld_q <= fold_vld[FOLD_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cmp_acc_q  <= acc_d;
      cmp_val_q  <= last.val;
      cmp_gate_q <= last.gate;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. An accepted value is clamped to the velocity range; a
  // skipped or rejected gate passes its input value through unchanged.
  // ---------------------------------------------------------------------------
  logic                    over_hi;
  logic                    over_lo;
  logic signed [VEL_W-1:0] res_d;
  logic                    sat_d;
  logic signed [VEL_W-1:0] out_value_q;
  logic                    out_acc_q;
  logic                    out_sat_q;

  assign over_hi = cmp_val_q > VEL_MAX_F;
  assign over_lo = cmp_val_q < VEL_MIN_F;

  always_comb begin
    res_d = cmp_gate_q;
    sat_d = 1'b0;
    if (cmp_acc_q) begin
      sat_d = over_hi || over_lo;
      if (over_hi) begin
        res_d = VEL_MAX_F[VEL_W-1:0];
      end else if (over_lo) begin
        res_d = VEL_MIN_F[VEL_W-1:0];
      end else begin
        res_d = cmp_val_q[VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= cmp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_value_q <= res_d;
      out_acc_q   <= cmp_acc_q;
      out_sat_q   <= sat_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.result_value = out_value_q;
  assign result_o.accepted     = out_acc_q;
  assign result_o.saturated    = out_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A stall freezes every valid bit of the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(ent_vld_q) && $stable(cmp_vld_q) && $stable(out_vld_q)))
    else $error("pipeline valid bits moved during a stall");

  // A gate that was skipped at the entry stage can never come out accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_vld_q && pipe_en && !$past(last.active, 1) && $past(pipe_en, 1)) |=> !out_acc_q)
    else $error("skipped gate was accepted");

  // Saturation is only reported for accepted gates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.saturated |-> result_o.accepted)
    else $error("saturated flag on a gate that was not accepted");

  // A rejected gate returns its own input value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && cmp_vld_q && !cmp_acc_q) |=> (result_o.result_value == $past(cmp_gate_q)))
    else $error("rejected gate did not return its input value");

endmodule

// ===== sv/dgru_fold_stage.sv =====
module dgru_fold_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [dgru_pkg::IDX_W-1:0]          idx_i,
  input  dgru_pkg::dgru_fold_cfg_t            cfg_i,
  input  logic                                vld_i,
  input  dgru_pkg::dgru_fold_t                item_i,
  output logic                                vld_o,
  output dgru_pkg::dgru_fold_t                item_o
);
  import dgru_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] limit;
  logic signed [FOLD_W-1:0] step;
  logic                     far;
  logic                     allowed;
  logic                     vld_q;
  dgru_fold_t               item_d;
  dgru_fold_t               item_q;

  // Distance from the value to the reference; the sign also says which way to fold.
  assign diff    = DIFF_W'(item_i.refv) - DIFF_W'(item_i.val);
  assign limit   = $signed(DIFF_W'(cfg_i.fold_limit));
  assign step    = $signed(FOLD_W'({cfg_i.nyquist, 1'b0}));
  assign far     = diff[DIFF_W-1] ? (diff < -limit) : (diff > limit);
  assign allowed = idx_i <= IDX_W'(cfg_i.max_folds);

  always_comb begin
    item_d = item_i;
    if (far && allowed) begin
      if (diff[DIFF_W-1]) begin
        item_d.val = item_i.val - step;
      end else begin
        item_d.val = item_i.val + step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import dgru_pkg::*;

  // The RTL register map leaves indexes 6 and 7 unused; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Run limit, well above the slowest correct run: about 560 items, each one
  // waiting out a long sender gap and a long result stall, plus the writes.
  localparam int CYCLE_LIMIT = 500000;

  // One gate as it goes into the block.
  typedef struct packed {
    logic signed [VEL_W-1:0] gate_value;
    logic                    gate_present;
    logic                    gate_eligible;
    logic signed [VEL_W-1:0] prev_value;
    logic                    prev_present;
    logic signed [VEL_W-1:0] sound_value;
    logic                    sound_present;
    logic signed [VEL_W-1:0] above_value;
    logic                    above_present;
  } gate_t;

  // The verdict that the block gives on one gate.
  typedef struct packed {
    logic signed [VEL_W-1:0] value;
    logic                    accepted;
    logic                    saturated;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  dgru_gate_if   gate_if ();
  dgru_result_if res_if ();

  doppler_gate_reference_unfold uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gate_i   (gate_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the settings registers, starting at their reset values.
  // The predictor reads these when a gate is accepted; they only change while
  // the pipeline is empty, so the copy always matches what the gate will see.
  logic [CFG_W-1:0]  cfg_nyquist    = CFG_W'(2000);
  logic [CFG_W-1:0]  cfg_fold_limit = CFG_W'(2000);
  logic [CFG_W-1:0]  cfg_comp_thr   = CFG_W'(500);
  logic [CFG_W-1:0]  cfg_min_speed  = '0;
  logic [MAXF_W-1:0] cfg_max_folds  = MAXF_W'(5);
  logic              cfg_have_last  = 1'b0;

  verdict_t verdicts_due[$];
  int       n_fail      = 0;
  int       n_cycles    = 0;
  bit       steady_flow = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A run that hangs ends here.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("** doppler_gate_reference_unfold: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint vel_gap(longint a, longint b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Folds the gate velocity toward a reference by steps of twice the Nyquist
  // velocity. It stops once the value is within the fold limit, or after
  // max_folds+1 steps, never more than the number of fold stages. The value
  // is kept wide here; only an accepted result gets clamped later.
  function automatic longint fold_toward_ref(longint vel, longint refv);
    longint step;
    longint lim;
    int     n_max;
    step  = 2 * longint'(cfg_nyquist);
    lim   = longint'(cfg_fold_limit);
    n_max = int'(cfg_max_folds) + 1;
    if (n_max > FOLD_STAGES) n_max = FOLD_STAGES;
    for (int n = 0; n < n_max; n++) begin
      if (vel_gap(refv, vel) <= lim) break;
      vel = (vel > refv) ? vel - step : vel + step;
    end
    return vel;
  endfunction

  // Works out the verdict on one gate under the current settings.
  function automatic verdict_t unfold_gate(gate_t g);
    verdict_t o;
    longint   vel;
    longint   folded;
    longint   thr;
    longint   vmax;
    longint   vmin;
    bit       ok;
    vel    = g.gate_value;
    folded = vel;
    thr    = longint'(cfg_comp_thr);
    vmax   = (longint'(1) <<< (VEL_W - 1)) - 1;
    vmin   = -vmax - 1;
    ok     = 1'b0;
    if (g.gate_eligible && g.gate_present && vel_gap(vel, 0) > longint'(cfg_min_speed)) begin
      if (!cfg_have_last) begin
        // Without a previous volume the sounding is mandatory. When the sweep
        // above is there too, fold toward it and check against both.
        if (g.sound_present) begin
          if (!g.above_present) begin
            folded = fold_toward_ref(vel, g.sound_value);
            ok     = vel_gap(g.sound_value, folded) < thr;
          end else begin
            folded = fold_toward_ref(vel, g.above_value);
            ok     = vel_gap(g.above_value, folded) < thr &&
                     vel_gap(g.sound_value, folded) < thr;
          end
        end
      end else if (g.prev_present && g.above_present) begin
        // With a previous volume, it is the fold target and the sweep above
        // must agree as well.
        folded = fold_toward_ref(vel, g.prev_value);
        ok     = vel_gap(g.prev_value, folded) < thr &&
                 vel_gap(g.above_value, folded) < thr;
      end
    end
    o.accepted  = ok;
    o.saturated = 1'b0;
    o.value     = g.gate_value;
    if (ok) begin
      if (folded > vmax) begin
        folded      = vmax;
        o.saturated = 1'b1;
      end else if (folded < vmin) begin
        folded      = vmin;
        o.saturated = 1'b1;
      end
      o.value = folded[VEL_W-1:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the check of every result.
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int       stall_left;
    int       calm_left;
    int       roll;
    verdict_t want;
    stall_left = 0;
    calm_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result_value: no result expected, got %0d", res_if.result_value);
          n_fail++;
        end else begin
          want = verdicts_due.pop_front();
          if (res_if.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, res_if.result_value);
            n_fail++;
          end
          if (res_if.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, res_if.accepted);
            n_fail++;
          end
          if (res_if.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, res_if.saturated);
            n_fail++;
          end
        end
      end
      // Stalls are mostly short, a few are long, and now and then there is a
      // long calm stretch in which every result is taken at once.
      if (calm_left > 0) begin
        calm_left--;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 2) calm_left = $urandom_range(100, 250);
        else if (roll < 5) stall_left = $urandom_range(10, 40);
        else if (roll < 22) stall_left = $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gate side and settings port
  // ---------------------------------------------------------------------------

  function automatic int sender_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item, waits until the block takes it, and records the verdict
  // that it must produce. Valid stays high after the handshake, so that a
  // following item can go out in the very next cycle.
  task automatic send_gate(input gate_t g);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      gate_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    gate_if.valid         <= 1'b1;
    gate_if.gate_value    <= g.gate_value;
    gate_if.gate_present  <= g.gate_present;
    gate_if.gate_eligible <= g.gate_eligible;
    gate_if.prev_value    <= g.prev_value;
    gate_if.prev_present  <= g.prev_present;
    gate_if.sound_value   <= g.sound_value;
    gate_if.sound_present <= g.sound_present;
    gate_if.above_value   <= g.above_value;
    gate_if.above_present <= g.above_present;
    do @(posedge clk_i); while (!gate_if.ready);
    verdicts_due.push_back(unfold_gate(g));
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain();
    gate_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // One APB write: a setup phase, then an access phase that lasts until pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Bits above a register's width are dropped; unused indexes change nothing.
    case (idx)
      REG_NYQUIST:    cfg_nyquist    = data[CFG_W-1:0];
      REG_FOLD_LIMIT: cfg_fold_limit = data[CFG_W-1:0];
      REG_COMP_THR:   cfg_comp_thr   = data[CFG_W-1:0];
      REG_MIN_SPEED:  cfg_min_speed  = data[CFG_W-1:0];
      REG_MAX_FOLDS:  cfg_max_folds  = data[MAXF_W-1:0];
      REG_HAVE_LAST:  cfg_have_last  = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int nyq, input int fold_lim, input int thr,
                            input int min_spd, input int max_f, input int have_last);
    drain();
    write_reg(REG_NYQUIST, nyq);
    write_reg(REG_FOLD_LIMIT, fold_lim);
    write_reg(REG_COMP_THR, thr);
    write_reg(REG_MIN_SPEED, min_spd);
    write_reg(REG_MAX_FOLDS, max_f);
    write_reg(REG_HAVE_LAST, have_last);
  endtask

  function automatic gate_t mk_gate(int gv, bit gp, bit ge, int pv, bit pp,
                                    int sv, bit sp, int av, bit ap);
    gate_t g;
    g.gate_value    = VEL_W'(gv);
    g.gate_present  = gp;
    g.gate_eligible = ge;
    g.prev_value    = VEL_W'(pv);
    g.prev_present  = pp;
    g.sound_value   = VEL_W'(sv);
    g.sound_present = sp;
    g.above_value   = VEL_W'(av);
    g.above_present = ap;
    return g;
  endfunction

  // Most random gates are built to reach the folding logic: a reference
  // velocity, a gate that sits a few folds away from it plus some jitter
  // around the threshold, and a second reference close to the first. The rest
  // are pure noise on every bit.
  function automatic gate_t random_gate();
    gate_t  g;
    longint base;
    longint second;
    longint gv;
    int     span;
    int     k;
    int     mf;
    g = $bits(gate_t)'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 4) != 0) begin
      mf   = int'(cfg_max_folds);
      span = int'(cfg_comp_thr) + 100;
      if ($urandom_range(0, 7) == 0) base = int'($urandom_range(0, 65535)) - 32768;
      else base = int'($urandom_range(0, 24000)) - 12000;
      second = base + int'($urandom_range(0, 2 * span)) - span;
      k  = int'($urandom_range(0, 2 * mf + 4)) - (mf + 2);
      gv = base + int'($urandom_range(0, 2 * span)) - span
           + longint'(k) * 2 * longint'(cfg_nyquist);
      if (gv > 32767) gv = 32767;
      if (gv < -32768) gv = -32768;
      if (second > 32767) second = 32767;
      if (second < -32768) second = -32768;
      g.gate_value    = gv[VEL_W-1:0];
      g.gate_present  = ($urandom_range(0, 19) != 0);
      g.gate_eligible = ($urandom_range(0, 19) != 0);
      if (cfg_have_last) begin
        g.prev_present  = ($urandom_range(0, 9) != 0);
        g.above_present = ($urandom_range(0, 9) != 0);
        g.prev_value    = base[VEL_W-1:0];
        g.above_value   = second[VEL_W-1:0];
      end else begin
        g.sound_present = ($urandom_range(0, 9) != 0);
        g.above_present = ($urandom_range(0, 9) < 5);
        if (g.above_present) begin
          g.above_value = base[VEL_W-1:0];
          g.sound_value = second[VEL_W-1:0];
        end else begin
          g.sound_value = base[VEL_W-1:0];
        end
      end
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Gates that must pass through untouched: not eligible, not present, not
  // faster than the minimum speed, or without the sounding that is required.
  task automatic test_skipped_gates();
    set_config(2000, 2000, 500, 0, 5, 0);
    send_gate(mk_gate(3900, 1, 0, 0, 0, -50, 1, 0, 0));
    send_gate(mk_gate(3900, 0, 1, 0, 0, -50, 1, 0, 0));
    send_gate(mk_gate(0, 1, 1, 0, 0, 0, 1, 0, 0));
    send_gate(mk_gate(3900, 1, 1, -50, 1, -50, 0, -50, 1));
    send_gate(mk_gate(-1, 1, 1, 0, 1, 0, 1, 0, 0));
  endtask

  // Sounding as the only reference, with the velocity extremes.
  task automatic test_sounding_reference();
    send_gate(mk_gate(32767, 1, 1, 0, 0, -100, 1, 0, 0));
    send_gate(mk_gate(-32768, 1, 1, 0, 0, 100, 1, 0, 0));
    send_gate(mk_gate(3900, 1, 1, 0, 0, -50, 1, 0, 0));
  endtask

  // Fold toward the sweep above; the sounding must agree as well.
  task automatic test_above_and_sounding();
    send_gate(mk_gate(3500, 1, 1, 0, 0, -300, 1, -400, 1));
    send_gate(mk_gate(3500, 1, 1, 0, 0, 2000, 1, -400, 1));
  endtask

  // The previous volume is the reference; both it and the sweep above are needed.
  task automatic test_last_volume();
    set_config(2000, 1999, 500, 0, 5, 1);
    send_gate(mk_gate(-3800, 1, 1, 150, 1, 0, 0, 100, 1));
    send_gate(mk_gate(-3800, 1, 1, 150, 0, 150, 1, 100, 1));
    send_gate(mk_gate(-3800, 1, 1, 150, 1, 150, 1, 100, 0));
    send_gate(mk_gate(-3800, 1, 1, 150, 1, 0, 0, 1500, 1));
  endtask

  // Accepted values that fold past the 16-bit range must clamp and flag it.
  task automatic test_saturation();
    set_config(10000, 10000, 10000, 0, 5, 0);
    send_gate(mk_gate(-20000, 1, 1, 0, 0, 32767, 1, 0, 0));
    send_gate(mk_gate(20000, 1, 1, 0, 0, -32768, 1, 0, 0));
  endtask

  // The fold count runs out at max_folds+1, both at its top and its bottom,
  // and the minimum speed is checked right at its boundary.
  task automatic test_fold_cap();
    set_config(1000, 0, 10000, 100, 15, 0);
    send_gate(mk_gate(-32768, 1, 1, 0, 0, 32767, 1, 0, 0));
    send_gate(mk_gate(100, 1, 1, 0, 0, 2000, 1, 0, 0));
    send_gate(mk_gate(-101, 1, 1, 0, 0, 1800, 1, 0, 0));
    set_config(1000, 0, 10000, 100, 0, 0);
    send_gate(mk_gate(-32768, 1, 1, 0, 0, 32767, 1, 0, 0));
  endtask

  // With a zero Nyquist velocity the folds leave the value alone; with a zero
  // threshold nothing can be accepted, since agreement must be strict.
  task automatic test_zero_settings();
    set_config(0, 0, 500, 0, 5, 0);
    send_gate(mk_gate(300, 1, 1, 0, 0, 0, 1, 0, 0));
    send_gate(mk_gate(5000, 1, 1, 0, 0, 0, 1, 0, 0));
    set_config(2000, 2000, 0, 0, 5, 0);
    send_gate(mk_gate(700, 1, 1, 0, 0, 700, 1, 0, 0));
  endtask

  // Upper bits written to a register must be dropped, and writes to the
  // unused indexes must leave every setting as it was.
  task automatic test_register_masking();
    drain();
    write_reg(REG_NYQUIST, 32'hFFFF_C000 | 32'd1000);
    write_reg(REG_MAX_FOLDS, 32'hFFFF_FFF2);
    write_reg(REG_HAVE_LAST, 32'hFFFF_FFFE);
    write_reg(REG_COMP_THR, 32'hFFFF_C000 | 32'd400);
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h0000_0001);
    send_gate(mk_gate(6100, 1, 1, 0, 0, 50, 1, 0, 0));
    send_gate(mk_gate(-8100, 1, 1, 0, 0, -50, 1, 0, 0));
  endtask

  // Random gates under several settings: two typical ones, both extremes, and two
  // random ones. Every so often a stretch goes out with no gaps at all.
  task automatic test_random_gates();
    int nyq;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(2000, 1999, 500, 100, 5, 0);
        1: set_config(1200, 1199, 300, 0, 3, 1);
        2: set_config(10000, 10000, 10000, 10000, 15, 0);
        3: set_config(0, 0, 0, 0, 0, 1);
        default: begin
          nyq = $urandom_range(0, 10000);
          set_config(nyq,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10000)
                                                 : ((nyq > 0) ? nyq - 1 : 0),
                     $urandom_range(0, nyq), $urandom_range(0, 1500),
                     $urandom_range(0, 15), $urandom_range(0, 1));
        end
      endcase
      for (int i = 0; i < 85; i++) begin
        if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        send_gate(random_gate());
      end
      steady_flow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    gate_if.valid         <= 1'b0;
    gate_if.gate_value    <= '0;
    gate_if.gate_present  <= 1'b0;
    gate_if.gate_eligible <= 1'b0;
    gate_if.prev_value    <= '0;
    gate_if.prev_present  <= 1'b0;
    gate_if.sound_value   <= '0;
    gate_if.sound_present <= 1'b0;
    gate_if.above_value   <= '0;
    gate_if.above_present <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first items run on the reset values of the registers.
    send_gate(mk_gate(3900, 1, 1, 0, 0, -50, 1, 0, 0));
    test_skipped_gates();
    test_sounding_reference();
    test_above_and_sounding();
    test_last_volume();
    test_saturation();
    test_fold_cap();
    test_zero_settings();
    test_register_masking();
    test_random_gates();

    // Every item has one result; after the last one, watch a little longer
    // for anything extra before the verdict.
    drain();
    repeat (40) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("** doppler_gate_reference_unfold: PASSED **");
    end else begin
      $display("** doppler_gate_reference_unfold: FAILED **");
    end
    $finish;
  end

endmodule
